/* src/gect_pkg.sv */
// Package for the grid escape cost tracker: constants, payload types and states.
package gect_pkg;

    localparam int MAX_SIDE = 32;
    localparam int CW       = $clog2(MAX_SIDE);
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int AW       = $clog2(CELLS);
    localparam int SW       = CW + 1;
    localparam logic [14:0] SUM_MAX = 15'h7FFF;

    typedef struct packed {
        logic [10:0] seat;
        logic        new_round;
    } t_in;

    typedef struct packed {
        logic [4:0]  cost;
        logic [14:0] total;
        logic        bad_seat;
    } t_out;

    typedef struct packed {
        logic [4:0]    lvl;
        logic [AW-1:0] loc;
    } t_qent;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_CHK,
        S_DIV,
        S_POP,
        S_POPW,
        S_NRD,
        S_NEV,
        S_FIN,
        S_DONE
    } t_state;

endpackage

/* src/grid_escape_cost_tracker.sv */
// Grid escape cost tracker: 0-1 search over a memory-held grid, one item at a time.
//
// Each item runs a visited-map sweep and a seat split, then pops cells from the search
// deque one at a time and checks each neighbor inside the grid; the search reads one
// neighbor at a time from the occupancy and visited memories.
// After reset the block sweeps all CELLS (1024) cells of both maps before it takes its
// first transfer; a new_round transfer clears the occupancy map during its own sweep.
// A finished result sits in an output register, so the next transfer is taken while
// it waits.
module grid_escape_cost_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gect_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gect_pkg::t_out     o_out_data,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata
);

    localparam int AW = gect_pkg::AW;
    localparam int CW = gect_pkg::CW;
    localparam int SW = gect_pkg::SW;

    logic                 vac_mem [gect_pkg::CELLS];
    logic                 vis_mem [gect_pkg::CELLS];
    gect_pkg::t_qent      q_mem   [gect_pkg::CELLS];

    gect_pkg::t_state r_state, n_state;
    logic [5:0]      r_side;
    logic [14:0]     r_sum, n_sum;
    logic [10:0]     r_seat, n_seat;
    logic            r_nr, n_nr;
    logic            r_clr_vac, n_clr_vac;
    logic            r_item, n_item;
    logic [AW:0]     r_cnt, n_cnt;
    logic [AW-1:0]   r_rem, n_rem;
    logic [CW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [AW:0]     r_qcnt, n_qcnt;
    gect_pkg::t_qent r_cur, n_cur;
    logic [1:0]      r_dir, n_dir;
    logic [AW-1:0]   r_nb, n_nb;
    logic [4:0]      r_cost, n_cost;
    logic            r_bad, n_bad;
    logic            r_ovalid, n_ovalid;
    gect_pkg::t_out  r_odata, n_odata;

    logic            r_vac_q, r_vis_q;
    gect_pkg::t_qent r_q_q;

    logic            vac_we, vac_wd, vis_we, vis_wd, q_we;
    logic [AW-1:0]   vac_wa, vis_wa, q_wa;
    gect_pkg::t_qent q_wd;

    logic [5:0]      side_n;
    logic [11:0]     side_sq;
    logic [CW-1:0]   cur_r, cur_c, nb_r, nb_c;
    logic            nb_ok;
    logic [15:0]     sum_ext;

    assign side_n  = (r_side == 6'd0) ? 6'd1 :
                     (r_side > 6'(gect_pkg::MAX_SIDE)) ? 6'(gect_pkg::MAX_SIDE) : r_side;
    assign side_sq = 12'(side_n) * 12'(side_n);
    assign cur_r   = r_cur.loc[AW-1:CW];
    assign cur_c   = r_cur.loc[CW-1:0];
    assign sum_ext = {1'b0, r_sum} + 16'(r_cost);

    always_comb begin
        nb_r  = cur_r;
        nb_c  = cur_c;
        nb_ok = 1'b0;
        unique case (r_dir)
            2'd0: begin
                nb_r  = cur_r + 1'b1;
                nb_ok = ({1'b0, cur_r} + 1'b1) < SW'(side_n);
            end
            2'd1: begin
                nb_c  = cur_c + 1'b1;
                nb_ok = ({1'b0, cur_c} + 1'b1) < SW'(side_n);
            end
            2'd2: begin
                nb_r  = cur_r - 1'b1;
                nb_ok = cur_r != '0;
            end
            default: begin
                nb_c  = cur_c - 1'b1;
                nb_ok = cur_c != '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_seat    = r_seat;
        n_nr      = r_nr;
        n_clr_vac = r_clr_vac;
        n_item    = r_item;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_row     = r_row;
        n_col     = r_col;
        n_head    = r_head;
        n_tail    = r_tail;
        n_qcnt    = r_qcnt;
        n_cur     = r_cur;
        n_dir     = r_dir;
        n_nb      = r_nb;
        n_cost    = r_cost;
        n_bad     = r_bad;
        n_ovalid  = r_ovalid & i_out_stall;
        n_odata   = r_odata;
        vac_we    = 1'b0;
        vac_wa    = r_cnt[AW-1:0];
        vac_wd    = 1'b0;
        vis_we    = 1'b0;
        vis_wa    = r_cnt[AW-1:0];
        vis_wd    = 1'b0;
        q_we      = 1'b0;
        q_wa      = r_tail;
        q_wd      = '{lvl: r_cur.lvl, loc: r_nb};
        o_in_stall = (r_state != gect_pkg::S_IDLE);

        unique case (r_state)
            gect_pkg::S_CLR: begin
                vis_we = 1'b1;
                vac_we = r_clr_vac;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(gect_pkg::CELLS - 1)) begin
                    n_state = r_item ? gect_pkg::S_CHK : gect_pkg::S_IDLE;
                end
            end
            gect_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_seat    = i_in_data.seat;
                    n_nr      = i_in_data.new_round;
                    n_clr_vac = i_in_data.new_round;
                    n_item    = 1'b1;
                    n_cnt     = '0;
                    n_state   = gect_pkg::S_CLR;
                    if (i_in_data.new_round) begin
                        n_sum = '0;
                    end
                end
            end
            gect_pkg::S_CHK: begin
                if (r_seat == '0 || {1'b0, r_seat} > side_sq) begin
                    n_cost  = '0;
                    n_bad   = 1'b1;
                    n_state = gect_pkg::S_DONE;
                end else begin
                    n_bad   = 1'b0;
                    n_rem   = AW'(r_seat - 11'd1);
                    n_row   = '0;
                    n_state = gect_pkg::S_DIV;
                end
            end
            gect_pkg::S_DIV: begin
                if (r_rem >= AW'(side_n)) begin
                    n_rem = r_rem - AW'(side_n);
                    n_row = r_row + 1'b1;
                end else begin
                    n_col   = r_rem[CW-1:0];
                    vis_we  = 1'b1;
                    vis_wa  = {r_row, r_rem[CW-1:0]};
                    vis_wd  = 1'b1;
                    q_we    = 1'b1;
                    q_wa    = '0;
                    q_wd    = '{lvl: 5'd0, loc: {r_row, r_rem[CW-1:0]}};
                    n_head  = '0;
                    n_tail  = AW'(1);
                    n_qcnt  = (AW+1)'(1);
                    n_state = gect_pkg::S_POP;
                end
            end
            gect_pkg::S_POP: begin
                if (r_qcnt == '0) begin
                    n_cost  = '0;
                    n_state = gect_pkg::S_FIN;
                end else begin
                    n_head  = r_head + 1'b1;
                    n_qcnt  = r_qcnt - 1'b1;
                    n_state = gect_pkg::S_POPW;
                end
            end
            gect_pkg::S_POPW: begin
                n_cur = r_q_q;
                n_dir = '0;
                n_state = gect_pkg::S_NRD;
                if (r_q_q.loc[AW-1:CW] == '0 || r_q_q.loc[CW-1:0] == '0 ||
                    {1'b0, r_q_q.loc[AW-1:CW]} == SW'(side_n - 6'd1) ||
                    {1'b0, r_q_q.loc[CW-1:0]} == SW'(side_n - 6'd1)) begin
                    n_cost  = r_q_q.lvl;
                    n_state = gect_pkg::S_FIN;
                end
            end
            gect_pkg::S_NRD: begin
                if (nb_ok) begin
                    n_nb    = {nb_r, nb_c};
                    n_state = gect_pkg::S_NEV;
                end else begin
                    n_dir   = r_dir + 1'b1;
                    n_state = (r_dir == 2'd3) ? gect_pkg::S_POP : gect_pkg::S_NRD;
                end
            end
            gect_pkg::S_NEV: begin
                if (!r_vis_q) begin
                    vis_we = 1'b1;
                    vis_wa = r_nb;
                    vis_wd = 1'b1;
                    q_we   = 1'b1;
                    n_qcnt = r_qcnt + 1'b1;
                    if (r_vac_q) begin
                        q_wa   = r_head - 1'b1;
                        n_head = r_head - 1'b1;
                    end else begin
                        q_wd.lvl = r_cur.lvl + 1'b1;
                        n_tail   = r_tail + 1'b1;
                    end
                end
                n_dir   = r_dir + 1'b1;
                n_state = (r_dir == 2'd3) ? gect_pkg::S_POP : gect_pkg::S_NRD;
            end
            gect_pkg::S_FIN: begin
                n_sum   = (sum_ext > 16'(gect_pkg::SUM_MAX)) ? gect_pkg::SUM_MAX :
                          sum_ext[14:0];
                vac_we  = 1'b1;
                vac_wa  = {r_row, r_col};
                vac_wd  = 1'b1;
                n_state = gect_pkg::S_DONE;
            end
            gect_pkg::S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{cost: r_cost, total: r_sum, bad_seat: r_bad};
                    n_item   = 1'b0;
                    n_state  = gect_pkg::S_IDLE;
                end
            end
            default: n_state = gect_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gect_pkg::S_CLR;
            r_side    <= 6'd32;
            r_sum     <= '0;
            r_clr_vac <= 1'b1;
            r_item    <= 1'b0;
            r_cnt     <= '0;
            r_qcnt    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
            end
            r_sum     <= n_sum;
            r_clr_vac <= n_clr_vac;
            r_item    <= n_item;
            r_cnt     <= n_cnt;
            r_qcnt    <= n_qcnt;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seat  <= n_seat;
        r_nr    <= n_nr;
        r_rem   <= n_rem;
        r_row   <= n_row;
        r_col   <= n_col;
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_cur   <= n_cur;
        r_dir   <= n_dir;
        r_nb    <= n_nb;
        r_cost  <= n_cost;
        r_bad   <= n_bad;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (vac_we) begin
            vac_mem[vac_wa] <= vac_wd;
        end
        r_vac_q <= vac_mem[n_nb];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        r_vis_q <= vis_mem[n_nb];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_wa] <= q_wd;
        end
        r_q_q <= q_mem[r_head];
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= (AW+1)'(gect_pkg::CELLS))
        else $error("search deque overfilled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gect_pkg::S_POPW) |-> $past(r_state) == gect_pkg::S_POP)
        else $error("deque data used without a pop");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gect_pkg::S_IDLE && i_in_valid) |=> r_state == gect_pkg::S_CLR)
        else $error("transfer taken without visited sweep");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gect_pkg::S_FIN) |=> r_sum >= $past(r_sum))
        else $error("running sum decreased");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gect_pkg::S_DONE && r_nr) |-> r_sum <= 15'(r_cost))
        else $error("new round did not clear the sum");

endmodule
